### sv/pmc_pkg.sv
package pmc_pkg;

   // controller states: run a step, or hold a result for the sink
   typedef enum logic [0:0] {
      ST_STEP,
      ST_HOLD
   } pmc_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic step;
      logic load_out;
   } pmc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic busy;
   } pmc_status_type;

   localparam int unsigned REQ_BITS  = 1 + 1 + 12 + 32 + 1 + 1 + 1 + 32 + 32;
   localparam int unsigned REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int unsigned RSP_BITS  = 1 + 32 + 1 + 1 + 10 + 32 + 1 + 1 + 12 + 32;
   localparam int unsigned RSP_BYTES = (RSP_BITS + 7) / 8;

endpackage

### sv/paged_memory_controller_top.sv
// Paged memory controller: a 12-bit virtual address (page in bits 11..8) is mapped
// onto FRAMES frames of an external frame RAM backed by a 16-page store, with FIFO
// replacement and write-back of dirty pages. Each req_ transfer carries one clock
// tick's worth of port values and yields exactly one rsp_ transfer with the strobes,
// held addresses and data for that tick. One item is worked per cycle; the next is
// taken in the cycle its result leaves the output register, so a continuously
// drained sink sees one item per clock. Page copies take one item per word.
module paged_memory_controller_top
   import pmc_pkg::*;
#(
   parameter int unsigned FRAMES     = 4,
   parameter int unsigned PAGE_WORDS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // req_read, req_write, req_addr[11:0], req_data[31:0], flush_all, ram_ready,
   // store_ready, ram_rdata[31:0], store_rdata[31:0], zero fill
   input  logic [REQ_BYTES*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // client_ready, client_rdata[31:0], ram_rd, ram_wr, ram_addr[9:0],
   // ram_wdata[31:0], store_rd, store_wr, store_addr[11:0], store_wdata[31:0], zero fill
   output logic [RSP_BYTES*8-1:0] rsp_tdata
);

   pmc_cmd_type    cmd;
   pmc_status_type status;

   pmc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   logic        ready, ram_rd, ram_wr, st_rd, st_wr;
   logic [31:0] rdata, ram_wdata, st_wdata;
   logic [9:0]  ram_addr;
   logic [11:0] st_addr;

   pmc_datapath #(.FRAMES(FRAMES), .PAGE_WORDS(PAGE_WORDS), .DATA_WIDTH(32)) u_dp (
      .clock, .reset, .cmd, .status,
      .i_rd(req_tdata[0]), .i_wr(req_tdata[1]), .i_addr(req_tdata[13:2]),
      .i_wdata(req_tdata[45:14]), .i_flush(req_tdata[46]), .i_rready(req_tdata[47]),
      .i_sready(req_tdata[48]), .i_rdata(req_tdata[80:49]), .i_sdata(req_tdata[112:81]),
      .o_ready(ready), .o_rdata(rdata), .o_ram_rd(ram_rd), .o_ram_wr(ram_wr),
      .o_ram_addr(ram_addr), .o_ram_wdata(ram_wdata), .o_st_rd(st_rd),
      .o_st_wr(st_wr), .o_st_addr(st_addr), .o_st_wdata(st_wdata)
   );

   assign rsp_tdata = {(RSP_BYTES*8-RSP_BITS)'(0), st_wdata, st_addr, st_wr, st_rd,
                       ram_wdata, ram_addr, ram_wr, ram_rd, rdata, ready};

endmodule

### sv/pmc_ctrl.sv
module pmc_ctrl
   import pmc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  pmc_status_type status,
   output pmc_cmd_type    cmd
);

   pmc_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_STEP: if (req_tvalid) state_in = ST_HOLD;
         ST_HOLD: if (rsp_tready) state_in = req_tvalid ? ST_HOLD : ST_STEP;
         default: state_in = ST_STEP;
      endcase
   end

   // outputs: a new item is taken whenever the output slot is free or draining
   always_comb begin
      rsp_tvalid   = (state_ff == ST_HOLD);
      req_tready   = (state_ff == ST_STEP) || rsp_tready;
      cmd.step     = req_tvalid && req_tready;
      cmd.load_out = cmd.step;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_STEP;
      else       state_ff <= state_in;
   end

   // a result is offered exactly after each transfer in, until taken
   a_out_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid) else $error("result lost");
   a_step_gate: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> req_tready) else $error("step without transfer");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
   a_status_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(status)) else $error("datapath status unknown");

endmodule

### sv/pmc_datapath.sv
module pmc_datapath
   import pmc_pkg::*;
#(
   parameter int unsigned FRAMES     = 4,
   parameter int unsigned PAGE_WORDS = 256,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pmc_cmd_type             cmd,
   output pmc_status_type          status,
   input  logic                    i_rd,
   input  logic                    i_wr,
   input  logic [11:0]             i_addr,
   input  logic [DATA_WIDTH-1:0]   i_wdata,
   input  logic                    i_flush,
   input  logic                    i_rready,
   input  logic                    i_sready,
   input  logic [DATA_WIDTH-1:0]   i_rdata,
   input  logic [DATA_WIDTH-1:0]   i_sdata,
   output logic                    o_ready,
   output logic [DATA_WIDTH-1:0]   o_rdata,
   output logic                    o_ram_rd,
   output logic                    o_ram_wr,
   output logic [9:0]              o_ram_addr,
   output logic [DATA_WIDTH-1:0]   o_ram_wdata,
   output logic                    o_st_rd,
   output logic                    o_st_wr,
   output logic [11:0]             o_st_addr,
   output logic [DATA_WIDTH-1:0]   o_st_wdata
);

   localparam int unsigned FB = $clog2(FRAMES);
   localparam logic [8:0] PW = 9'(PAGE_WORDS);
   localparam logic [2:0] FR = 3'(FRAMES);

   logic [3:0]  tag_ff [FRAMES], tag_in [FRAMES];
   logic [FRAMES-1:0] dirty_ff, dirty_in;
   logic [1:0]  vptr_ff, vptr_in;
   logic [2:0]  fptr_ff, fptr_in;
   logic [8:0]  woff_ff, woff_in;
   logic [11:0] haddr_ff, haddr_in;
   logic [3:0]  hpage_ff, hpage_in;
   logic [1:0]  cur_ff, cur_in;
   logic [DATA_WIDTH-1:0] hdata_ff, hdata_in;
   logic prd_ff, prd_in, pwr_ff, pwr_in, hit_ff, hit_in, aw_ff, aw_in;
   logic sw_ff, sw_in, fl_ff, fl_in, vs_ff, vs_in, emp_ff, emp_in;
   logic [9:0]  ra_ff, ra_in;
   logic [11:0] sa_ff, sa_in;
   logic [DATA_WIDTH-1:0] rw_ff, rw_in, sw_d_ff, sw_d_in;
   logic rdy_c, rrd_c, rwr_c, srd_c, swr_c;
   logic [DATA_WIDTH-1:0] rdat_c;

   assign status.busy = sw_ff || fl_ff;

   // one model step: tag match, flush walk, hit access, write-back and fetch
   always_comb begin
      logic [FB-1:0] f;
      logic lock;
      tag_in = tag_ff; dirty_in = dirty_ff; vptr_in = vptr_ff; fptr_in = fptr_ff;
      woff_in = woff_ff; haddr_in = haddr_ff; hpage_in = hpage_ff; cur_in = cur_ff;
      hdata_in = hdata_ff; prd_in = prd_ff; pwr_in = pwr_ff; hit_in = hit_ff;
      aw_in = aw_ff; sw_in = sw_ff; fl_in = fl_ff; vs_in = vs_ff; emp_in = emp_ff;
      ra_in = ra_ff; sa_in = sa_ff; rw_in = rw_ff; sw_d_in = sw_d_ff;
      rrd_c = 1'b0; rwr_c = 1'b0; srd_c = 1'b0; swr_c = 1'b0; lock = 1'b0;
      rdat_c = '0;
      if (!fl_in) fl_in = i_flush;
      rdy_c = i_rready && i_sready;
      // latch a new request and match tags
      if (!sw_in && (i_rd || i_wr) && !fl_in) begin
         haddr_in = i_addr; hpage_in = i_addr[11:8];
         prd_in = i_rd; pwr_in = i_wr; hdata_in = i_wdata; hit_in = 1'b0;
         if (!emp_in) begin
            cur_in = vptr_in;
            for (int i = 0; i < FRAMES; i++)
               if (tag_in[i] == hpage_in) begin
                  cur_in = 2'(i); hit_in = 1'b1;
               end
         end
         rdy_c = 1'b0;
      end
      // flush walk
      if (fl_in && !vs_in) begin
         hpage_in = '0; aw_in = 1'b0;
         if (fptr_in >= FR) begin
            cur_in = 2'(FRAMES - 1); fptr_in = '0; fl_in = 1'b0;
         end else begin
            cur_in = fptr_in[1:0]; fptr_in = fptr_in + 3'd1;
         end
      end
      f = cur_in[FB-1:0];
      // hit access
      if (hit_in && i_rready && !fl_in) begin
         if (aw_in) begin
            rdy_c = 1'b1; rdat_c = i_rdata; aw_in = 1'b0;
         end
         if (pwr_in) begin
            rwr_c = 1'b1; rw_in = hdata_in;
            ra_in = {2'(f), haddr_in[7:0]};
            rdat_c = '0; rdy_c = 1'b0; dirty_in[f] = 1'b1; pwr_in = 1'b0;
         end
         if (prd_in) begin
            rrd_c = 1'b1; ra_in = {2'(f), haddr_in[7:0]};
            rdat_c = '0; rdy_c = 1'b0; prd_in = 1'b0; aw_in = 1'b1;
         end
      end
      if (fl_in && dirty_in[f]) vs_in = 1'b1;
      // write-back of a dirty frame, then fetch of the new page
      if ((!hit_in || fl_in) && i_rready && i_sready) begin
         sw_in = 1'b1;
         if (dirty_in[f]) begin
            if (aw_in) begin
               swr_c = 1'b1; sw_d_in = i_rdata;
               sa_in = {tag_in[f], 8'h00} + 12'(woff_in);
               lock = 1'b1; woff_in = woff_in + 9'd1; aw_in = 1'b0;
            end
            if (woff_in < PW) begin
               rrd_c = 1'b1; ra_in = {2'(f), 8'h00} + 10'(woff_in); aw_in = 1'b1;
            end else begin
               tag_in[f] = hpage_in; dirty_in[f] = 1'b0; woff_in = '0; vs_in = 1'b0;
            end
            rdy_c = 1'b0;
         end
         if (!dirty_in[f] && !lock && !fl_in) begin
            if (aw_in) begin
               rwr_c = 1'b1; rw_in = i_sdata;
               ra_in = {2'(f), 8'h00} + 10'(woff_in);
               woff_in = woff_in + 9'd1; aw_in = 1'b0;
            end
            if (woff_in < PW) begin
               srd_c = 1'b1; sa_in = {haddr_in[11:8], 8'h00} + 12'(woff_in);
               aw_in = 1'b1;
            end else begin
               emp_in = 1'b0; woff_in = '0; sw_in = 1'b0; dirty_in[f] = 1'b0;
               tag_in[f] = hpage_in; hit_in = 1'b1;
               vptr_in = (3'(vptr_in) + 3'd1 >= FR) ? 2'd0 : vptr_in + 2'd1;
            end
            rdy_c = 1'b0;
         end
      end
   end

   // state registers advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) tag_ff[i] <= '0;
         dirty_ff <= '0; vptr_ff <= '0; fptr_ff <= '0; woff_ff <= '0;
         haddr_ff <= '0; hpage_ff <= '0; cur_ff <= '0; hdata_ff <= '0;
         prd_ff <= 1'b0; pwr_ff <= 1'b0; hit_ff <= 1'b0; aw_ff <= 1'b0;
         sw_ff <= 1'b0; fl_ff <= 1'b0; vs_ff <= 1'b0; emp_ff <= 1'b1;
         ra_ff <= '0; sa_ff <= '0; rw_ff <= '0; sw_d_ff <= '0;
      end else if (cmd.step) begin
         tag_ff <= tag_in; dirty_ff <= dirty_in; vptr_ff <= vptr_in;
         fptr_ff <= fptr_in; woff_ff <= woff_in; haddr_ff <= haddr_in;
         hpage_ff <= hpage_in; cur_ff <= cur_in; hdata_ff <= hdata_in;
         prd_ff <= prd_in; pwr_ff <= pwr_in; hit_ff <= hit_in; aw_ff <= aw_in;
         sw_ff <= sw_in; fl_ff <= fl_in; vs_ff <= vs_in; emp_ff <= emp_in;
         ra_ff <= ra_in; sa_ff <= sa_in; rw_ff <= rw_in; sw_d_ff <= sw_d_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_ready <= rdy_c; o_rdata <= rdat_c; o_ram_rd <= rrd_c; o_ram_wr <= rwr_c;
         o_ram_addr <= ra_in; o_ram_wdata <= rw_in; o_st_rd <= srd_c;
         o_st_wr <= swr_c; o_st_addr <= sa_in; o_st_wdata <= sw_d_in;
      end
   end

   a_wb_only_dirty: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && swr_c) |-> dirty_ff[cur_in[FB-1:0]]) else $error("clean write-back");
   a_fptr_range: assert property (@(posedge clock) disable iff (reset)
      fptr_ff <= FR) else $error("flush pointer past end");
   a_strobes: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !(srd_c && swr_c)) else $error("store read and write");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb
   import pmc_pkg::*;
;

   // one tick of controller outputs
   typedef struct {
      logic        client_ready;
      logic [31:0] client_rdata;
      logic        ram_rd;
      logic        ram_wr;
      logic [9:0]  ram_addr;
      logic [31:0] ram_wdata;
      logic        store_rd;
      logic        store_wr;
      logic [11:0] store_addr;
      logic [31:0] store_wdata;
   } tick_out_type;

   // paging predictor and store of expected ticks
   class paging_scoreboard;
      logic [3:0]  tag [4];
      logic        dirty [4];
      logic [1:0]  victim;
      logic [2:0]  flush_idx;
      logic [8:0]  word;
      logic [11:0] h_addr;
      logic [3:0]  h_page;
      logic [1:0]  frame;
      logic [31:0] h_data;
      logic        p_read, p_write, hit, waiting, swap, flush, saving, empty;
      logic [9:0]  o_raddr;
      logic [31:0] o_rwdata;
      logic [11:0] o_saddr;
      logic [31:0] o_swdata;
      tick_out_type pending_ticks [$];
      int          errors;

      function new();
         for (int i = 0; i < 4; i++) begin
            tag[i] = '0;
            dirty[i] = 1'b0;
         end
         victim = '0; flush_idx = '0; word = '0; h_addr = '0; h_page = '0;
         frame = '0; h_data = '0;
         p_read = 0; p_write = 0; hit = 0; waiting = 0; swap = 0; flush = 0;
         saving = 0; empty = 1;
         o_raddr = '0; o_rwdata = '0; o_saddr = '0; o_swdata = '0;
         errors = 0;
      endfunction

      // advance the predictor by one accepted input transfer
      function void note_tick(logic [REQ_BYTES*8-1:0] d);
         logic        rd, wr, fl, rr, sr, locked, rdy;
         logic [11:0] a;
         logic [31:0] wd, rdat, sdat, cdata;
         logic [1:0]  f;
         tick_out_type t;
         rd = d[0]; wr = d[1]; a = d[13:2]; wd = d[45:14]; fl = d[46];
         rr = d[47]; sr = d[48]; rdat = d[80:49]; sdat = d[112:81];
         t.ram_rd = 0; t.ram_wr = 0; t.store_rd = 0; t.store_wr = 0;
         locked = 0; cdata = '0;
         if (!flush) flush = fl;
         rdy = rr && sr;
         // latch a new request when idle
         if (!swap && (rd || wr) && !flush) begin
            h_addr = a; h_page = a[11:8]; p_read = rd; p_write = wr; h_data = wd;
            hit = 0;
            if (!empty) begin
               frame = victim;
               for (int i = 0; i < 4; i++)
                  if (tag[i] == h_page) begin
                     frame = i[1:0];
                     hit = 1;
                  end
            end
            rdy = 0;
         end
         // flush walk, ending after the last frame
         if (flush && !saving) begin
            h_page = '0; waiting = 0;
            if (flush_idx >= 4) begin
               frame = 2'd3; flush_idx = '0; flush = 0;
            end else begin
               frame = flush_idx[1:0]; flush_idx = flush_idx + 1'b1;
            end
         end
         f = frame;
         // hit access
         if (hit && rr && !flush) begin
            if (waiting) begin
               rdy = 1; cdata = rdat; waiting = 0;
            end
            if (p_write) begin
               t.ram_wr = 1; o_rwdata = h_data; o_raddr = {f, h_addr[7:0]};
               cdata = '0; rdy = 0; dirty[f] = 1; p_write = 0;
            end
            if (p_read) begin
               t.ram_rd = 1; o_raddr = {f, h_addr[7:0]};
               cdata = '0; rdy = 0; p_read = 0; waiting = 1;
            end
         end
         if (flush && dirty[f]) saving = 1;
         // page copy: write-back of a dirty victim, then fetch
         if ((!hit || flush) && rr && sr) begin
            swap = 1;
            if (dirty[f]) begin
               if (waiting) begin
                  t.store_wr = 1; o_swdata = rdat;
                  o_saddr = {tag[f], 8'h00} + {3'b000, word};
                  locked = 1; word = word + 1'b1; waiting = 0;
               end
               if (word < 256) begin
                  t.ram_rd = 1; o_raddr = {f, 8'h00} + {1'b0, word}; waiting = 1;
               end else begin
                  tag[f] = h_page; dirty[f] = 0; word = '0; saving = 0;
               end
               rdy = 0;
            end
            if (!dirty[f] && !locked && !flush) begin
               if (waiting) begin
                  t.ram_wr = 1; o_rwdata = sdat; o_raddr = {f, 8'h00} + {1'b0, word};
                  word = word + 1'b1; waiting = 0;
               end
               if (word < 256) begin
                  t.store_rd = 1; o_saddr = {h_addr[11:8], 8'h00} + {3'b000, word};
                  waiting = 1;
               end else begin
                  empty = 0; word = '0; swap = 0; dirty[f] = 0; tag[f] = h_page;
                  hit = 1; victim = (victim == 2'd3) ? 2'd0 : victim + 1'b1;
               end
               rdy = 0;
            end
         end
         t.client_ready = rdy; t.client_rdata = cdata;
         t.ram_addr = o_raddr; t.ram_wdata = o_rwdata;
         t.store_addr = o_saddr; t.store_wdata = o_swdata;
         pending_ticks.push_back(t);
      endfunction

      // compare one output transfer with the oldest expected tick
      function void check_tick(logic [RSP_BYTES*8-1:0] r);
         tick_out_type e;
         if (pending_ticks.size() == 0) begin
            $error("unexpected result transfer %h", r);
            errors++;
            return;
         end
         e = pending_ticks.pop_front();
         if (r[0] !== e.client_ready) begin
            $error("client_ready exp %h got %h", e.client_ready, r[0]); errors++;
         end
         if (r[32:1] !== e.client_rdata) begin
            $error("client_rdata exp %h got %h", e.client_rdata, r[32:1]); errors++;
         end
         if (r[33] !== e.ram_rd) begin
            $error("ram_rd exp %h got %h", e.ram_rd, r[33]); errors++;
         end
         if (r[34] !== e.ram_wr) begin
            $error("ram_wr exp %h got %h", e.ram_wr, r[34]); errors++;
         end
         if (r[44:35] !== e.ram_addr) begin
            $error("ram_addr exp %h got %h", e.ram_addr, r[44:35]); errors++;
         end
         if (r[76:45] !== e.ram_wdata) begin
            $error("ram_wdata exp %h got %h", e.ram_wdata, r[76:45]); errors++;
         end
         if (r[77] !== e.store_rd) begin
            $error("store_rd exp %h got %h", e.store_rd, r[77]); errors++;
         end
         if (r[78] !== e.store_wr) begin
            $error("store_wr exp %h got %h", e.store_wr, r[78]); errors++;
         end
         if (r[90:79] !== e.store_addr) begin
            $error("store_addr exp %h got %h", e.store_addr, r[90:79]); errors++;
         end
         if (r[122:91] !== e.store_wdata) begin
            $error("store_wdata exp %h got %h", e.store_wdata, r[122:91]); errors++;
         end
      endfunction
   endclass

   localparam int RANDOM_TICKS = 480;
   localparam int IDLE_LIMIT   = 5000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_BYTES*8-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_BYTES*8-1:0] rsp_tdata;

   paging_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  long_hold   = 0;
   bit  hold_done   = 0;

   paged_memory_controller_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // pack one tick of input port values
   function automatic logic [REQ_BYTES*8-1:0] pack_tick(
      logic rd, logic wr, logic [11:0] a, logic [31:0] wd, logic fl,
      logic rr, logic sr, logic [31:0] rdat, logic [31:0] sdat);
      logic [REQ_BYTES*8-1:0] d;
      d = '0;
      d[0] = rd; d[1] = wr; d[13:2] = a; d[45:14] = wd; d[46] = fl;
      d[47] = rr; d[48] = sr; d[80:49] = rdat; d[112:81] = sdat;
      return d;
   endfunction

   // offer one transfer and wait until it is taken
   task automatic send_tick(logic [REQ_BYTES*8-1:0] d, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_tick(d);
      @(negedge clock);
   endtask

   // random tick, mostly well-formed traffic on a few pages
   function automatic logic [REQ_BYTES*8-1:0] random_tick();
      logic [11:0] a;
      logic        rd, wr;
      a = {($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, 5)),
           8'($urandom)};
      rd = $urandom_range(0, 2) == 0;
      wr = $urandom_range(0, 2) == 0;
      return pack_tick(rd, wr, a, $urandom, $urandom_range(0, 199) == 0,
                       $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
                       $urandom, $urandom);
   endfunction

   // stimulus
   initial begin
      int burst;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed ticks
      send_tick(pack_tick(0, 0, 12'h000, 32'h0, 0, 0, 0, 32'h0, 32'h0), 0);
      send_tick(pack_tick(1, 0, 12'h000, 32'h0, 0, 1, 1, '1, '1), 0);
      send_tick(pack_tick(0, 1, 12'hFFF, '1, 0, 1, 1, 32'h0, '1), 0);
      send_tick(pack_tick(1, 1, 12'h0FF, '1, 0, 0, 1, '1, 32'h0), 0);
      send_tick(pack_tick(1, 1, 12'hF00, 32'h5A5A5A5A, 0, 1, 0, 32'h0, '1), 0);
      send_tick(pack_tick(0, 0, 12'h000, 32'h0, 1, 1, 1, '1, '1), 0);
      send_tick(pack_tick(1, 1, 12'h123, '1, 1, 1, 1, '1, '1), 0);
      send_tick(pack_tick(0, 0, 12'h000, 32'h0, 1, 0, 0, 32'h0, 32'h0), 0);
      for (int i = 0; i < 12; i++)
         send_tick(pack_tick(i[0], i[1], {i[3:0], 8'hFF}, ~i, i == 11, 1, 1,
                   32'hA5A5A5A5 ^ i, ~32'h0 ^ i), 0);

      // random ticks in bursts with gaps
      burst = 0;
      for (int i = 0; i < RANDOM_TICKS; i++) begin
         int gap;
         gap = 0;
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap   = (i < 150 || i > 300) ? $urandom_range(0, 4) : 0;
         end
         burst--;
         if (i == 200) long_hold = 1;
         send_tick(random_tick(), gap);
      end
      req_tvalid <= 1'b0;

      wait (sb.pending_ticks.size() == 0);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // receiver: stall pattern, one long hold-off, and a clean stretch
   initial begin
      int cyc;
      cyc = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (long_hold && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_done = 1;
         end
         if ((cyc / 500) % 3 == 2)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ((cyc % 7) < 4) || ($urandom_range(0, 3) == 0);
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_tick(rsp_tdata);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
